// ----- hw/rtl/imucal_pkg.sv -----
// ----------------------------------------------------------------------------
// imucal_pkg - shared types and constants of the IMU calibration filter
// Widths, phase codes, register indexes and the lane control/status structs.
// ----------------------------------------------------------------------------
package imucal_pkg;

  // Field widths
  localparam int SAMPLE_W    = 16;
  localparam int OUT_W       = SAMPLE_W + 1;
  localparam int NOISE_OUT_W = SAMPLE_W;
  localparam int CNT_W       = 11;
  localparam int ALPHA_W     = 9;
  localparam int PHASE_W     = 2;
  localparam int CFG_DATA_W  = 11;

  // Internal widths: an offset can grow past the sample range when the
  // count is lowered in the middle of the averaging phase
  localparam int SUM_W   = 27;
  localparam int OFF_W   = 26;
  localparam int DIFF_W  = 27;
  localparam int NOISE_W = 26;
  localparam int PROD_W  = 37;

  // Limits and reset values
  localparam int MAX_SAMPLES      = 1024;
  localparam int ALPHA_ONE        = 256;
  localparam int ALPHA_SHIFT      = 8;
  localparam int SAMPLE_COUNT_RST = 100;
  localparam int FILTER_ALPHA_RST = 192;

  // Divider: one quotient bit per cycle over the dividend magnitude
  localparam int DIV_STEPS = OFF_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Sensor phases
  localparam logic [PHASE_W-1:0] PH_AVG   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_NOISE = 2'd1;
  localparam logic [PHASE_W-1:0] PH_RUN   = 2'd2;

  // Sensor codes
  localparam logic SNS_ACCEL = 1'b0;
  localparam logic SNS_GYRO  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_SAMPLE_COUNT = 1'b0;
  localparam logic CFG_FILTER_ALPHA = 1'b1;

  localparam int NUM_LANES = 3;

  // Control from the sequencer to every axis lane
  typedef struct packed {
    logic               sensor;
    logic [PHASE_W-1:0] phase;
    logic               done;
    logic               mul_en;
    logic               fin_en;
    logic [ALPHA_W-1:0] alpha;
    logic [CNT_W-1:0]   n;
  } lane_ctrl_t;

  // Status from one axis lane back to the merging stage
  typedef struct packed {
    logic                   q_valid;
    logic [OUT_W-1:0]       res;
    logic [NOISE_OUT_W-1:0] noise;
  } lane_stat_t;

endpackage

// ----- hw/rtl/imucal_div.sv -----
// ----------------------------------------------------------------------------
// imucal_div - signed by unsigned restoring divider
// Truncates toward zero; one quotient bit per cycle.
// ----------------------------------------------------------------------------
module imucal_div
  import imucal_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0]        divisor,
  output logic                    q_valid,
  output logic signed [OFF_W-1:0] quotient
);

  logic                 busy_r;
  logic                 q_valid_r;
  logic [DIV_CNT_W-1:0] step_r;
  logic [CNT_W-1:0]     rem_r;
  logic [OFF_W-1:0]     q_r;
  logic [CNT_W-1:0]     div_r;
  logic                 neg_r;

  logic [SUM_W-1:0]     mag_full;
  logic [CNT_W:0]       rem_sh;
  logic                 ge;
  logic [CNT_W:0]       rem_sub;

  // Magnitude of the dividend
  assign mag_full = dividend[SUM_W-1] ? (-dividend) : dividend;

  // Shift in the next dividend bit and try a subtraction
  assign rem_sh  = {rem_r, q_r[OFF_W-1]};
  assign ge      = (rem_sh >= {1'b0, div_r});
  assign rem_sub = rem_sh - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      q_valid_r <= 1'b0;
      step_r    <= '0;
    end else begin
      q_valid_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r    <= 1'b0;
          q_valid_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: load on start, iterate while busy
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= mag_full[OFF_W-1:0];
      div_r <= divisor;
      neg_r <= dividend[SUM_W-1];
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      q_r   <= {q_r[OFF_W-2:0], ge};
    end
  end

  assign q_valid  = q_valid_r;
  assign quotient = neg_r ? (-$signed(q_r)) : $signed(q_r);

endmodule

// ----- hw/rtl/imucal_lane.sv -----
// ----------------------------------------------------------------------------
// imucal_lane - one axis of the calibration filter
// Holds sum, offset and noise for both sensors and the accel filter state;
// subtracts the offset, runs the low-pass filter and the phase updates.
// ----------------------------------------------------------------------------
module imucal_lane
  import imucal_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  lane_ctrl_t                 ctrl,
  input  logic signed [SAMPLE_W-1:0] sample,
  output lane_stat_t                 stat
);

  logic signed [SUM_W-1:0]  sum_r   [2];
  logic signed [OFF_W-1:0]  off_r   [2];
  logic [NOISE_W-1:0]       noise_r [2];
  logic signed [DIFF_W-1:0] filt_r;

  logic signed [DIFF_W-1:0] diff_r;
  logic [NOISE_W-1:0]       abs_r;
  logic signed [PROD_W-1:0] prod_new_r;
  logic signed [PROD_W-1:0] prod_old_r;
  logic [OUT_W-1:0]         res_r;
  logic [NOISE_OUT_W-1:0]   noise_res_r;

  logic signed [DIFF_W-1:0] diff_nxt;
  logic signed [DIFF_W-1:0] abs_full;
  logic signed [ALPHA_W:0]  w_new;
  logic signed [ALPHA_W:0]  w_old;
  logic signed [PROD_W-1:0] fsum;
  logic signed [PROD_W-1:0] fsum_adj;
  logic signed [PROD_W-1:0] fshift;
  logic signed [DIFF_W-1:0] filt_nxt;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic [NOISE_W-1:0]       noise_nxt;
  logic                     div_start;
  logic                     q_valid;
  logic signed [OFF_W-1:0]  quotient;

  // Offset subtraction and filter weights
  assign diff_nxt = DIFF_W'(sample) - DIFF_W'(off_r[ctrl.sensor]);
  assign abs_full = diff_nxt[DIFF_W-1] ? (-diff_nxt) : diff_nxt;
  assign w_new    = $signed({1'b0, ctrl.alpha});
  assign w_old    = $signed({1'b0, ALPHA_W'(ALPHA_ONE) - ctrl.alpha});

  // Filter sum, divided by 256 with truncation toward zero
  assign fsum     = prod_new_r + prod_old_r;
  assign fsum_adj = fsum + (fsum[PROD_W-1] ? PROD_W'(ALPHA_ONE - 1) : '0);
  assign fshift   = fsum_adj >>> ALPHA_SHIFT;
  assign filt_nxt = fshift[DIFF_W-1:0];

  // Accumulate and track the peak deviation
  assign sum_nxt   = sum_r[ctrl.sensor] + SUM_W'(sample);
  assign noise_nxt = ((ctrl.phase == PH_NOISE) && (abs_r > noise_r[ctrl.sensor]))
                     ? abs_r : noise_r[ctrl.sensor];
  assign div_start = ctrl.fin_en && (ctrl.phase == PH_AVG) && ctrl.done;

  // Multiply stage
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      diff_r     <= diff_nxt;
      abs_r      <= abs_full[NOISE_W-1:0];
      prod_new_r <= w_new * diff_nxt;
      prod_old_r <= w_old * filt_r;
    end
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (ctrl.fin_en) begin
      res_r       <= (ctrl.sensor == SNS_ACCEL) ? filt_nxt[OUT_W-1:0] : diff_r[OUT_W-1:0];
      noise_res_r <= noise_nxt[NOISE_OUT_W-1:0];
    end
  end

  // Calibration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r[0]   <= '0;
      sum_r[1]   <= '0;
      off_r[0]   <= '0;
      off_r[1]   <= '0;
      noise_r[0] <= '0;
      noise_r[1] <= '0;
      filt_r     <= '0;
    end else begin
      if (ctrl.fin_en) begin
        if (ctrl.sensor == SNS_ACCEL) begin
          filt_r <= filt_nxt;
        end
        if (ctrl.phase == PH_AVG) begin
          sum_r[ctrl.sensor] <= sum_nxt;
        end
        noise_r[ctrl.sensor] <= noise_nxt;
      end
      if (q_valid) begin
        off_r[ctrl.sensor] <= quotient;
      end
    end
  end

  // Offset = sum / n
  imucal_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (ctrl.n),
    .q_valid  (q_valid),
    .quotient (quotient)
  );

  assign stat.q_valid = q_valid;
  assign stat.res     = res_r;
  assign stat.noise   = noise_res_r;

endmodule

// ----- hw/rtl/imu_offset_noise_calibrate_filter_core.sv -----
// ----------------------------------------------------------------------------
// imu_offset_noise_calibrate_filter_core - IMU offset calibration and filter
// Three axis lanes in parallel, a phase sequencer and a result register.
// ----------------------------------------------------------------------------
// One request is processed at a time. A sample passes from acceptance to
// the output register in steps: accept, multiply, filter and state update,
// result load; the sample that closes a sensor's averaging phase also waits
// for the bit-serial offset divider in each lane before the result load.
// The next request is accepted as soon as the previous result is in the
// output register, even while that result still waits to be taken.
// Configuration writes are always accepted.
module imu_offset_noise_calibrate_filter_core
  import imucal_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  // Sample request
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic signed [SAMPLE_W-1:0]    in_sample_x,
  input  logic signed [SAMPLE_W-1:0]    in_sample_y,
  input  logic signed [SAMPLE_W-1:0]    in_sample_z,
  // Result request
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OUT_W-1:0]       out_x,
  output logic signed [OUT_W-1:0]       out_y,
  output logic signed [OUT_W-1:0]       out_z,
  output logic [NOISE_OUT_W-1:0]        out_noise_x,
  output logic [NOISE_OUT_W-1:0]        out_noise_y,
  output logic [NOISE_OUT_W-1:0]        out_noise_z,
  output logic [PHASE_W-1:0]            out_phase,
  // Configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_FIN  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_WB   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]          sample_count_r;
  logic [ALPHA_W-1:0]        filter_alpha_r;
  logic [PHASE_W-1:0]        phase_r [2];
  logic [CNT_W-1:0]          cnt_r   [2];
  logic                      sensor_r;
  logic signed [SAMPLE_W-1:0] smp_r  [NUM_LANES];
  logic [PHASE_W-1:0]        phase_res_r;

  logic                      out_valid_r;
  logic [OUT_W-1:0]          out_res_r   [NUM_LANES];
  logic [NOISE_OUT_W-1:0]    out_noise_r [NUM_LANES];
  logic [PHASE_W-1:0]        out_phase_r;

  logic [CNT_W-1:0]          n_eff;
  logic [ALPHA_W-1:0]        alpha_eff;
  logic [CNT_W-1:0]          cnt_inc;
  logic                      done;
  logic                      in_acc;
  logic                      out_free;
  logic [PHASE_W-1:0]        cur_phase;
  lane_ctrl_t                ctrl;
  lane_stat_t                stat [NUM_LANES];
  logic [NUM_LANES-1:0]      q_valid_vec;

  // Clamp the configuration to its working range
  always_comb begin
    if (sample_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (sample_count_r > CNT_W'(MAX_SAMPLES)) begin
      n_eff = CNT_W'(MAX_SAMPLES);
    end else begin
      n_eff = sample_count_r;
    end
    alpha_eff = (filter_alpha_r > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : filter_alpha_r;
  end

  assign cur_phase = phase_r[sensor_r];
  assign cnt_inc   = cnt_r[sensor_r] + 1'b1;
  assign done      = (cnt_inc >= n_eff);
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= CNT_W'(SAMPLE_COUNT_RST);
      filter_alpha_r <= ALPHA_W'(FILTER_ALPHA_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SAMPLE_COUNT: sample_count_r <= cfg_wdata;
        CFG_FILTER_ALPHA: filter_alpha_r <= cfg_wdata[ALPHA_W-1:0];
        default:          ;
      endcase
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sensor_r <= in_opcode;
      smp_r[0] <= in_sample_x;
      smp_r[1] <= in_sample_y;
      smp_r[2] <= in_sample_z;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ((cur_phase == PH_AVG) && done) ? ST_DIV : ST_WB;
      ST_DIV:  if (&q_valid_vec) state_nxt = ST_WB;
      ST_WB:   if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Phase and sample counters, advanced once per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r[0] <= PH_AVG;
      phase_r[1] <= PH_AVG;
      cnt_r[0]   <= '0;
      cnt_r[1]   <= '0;
    end else if (state_r == ST_FIN) begin
      priority if (cur_phase == PH_AVG) begin
        if (done) begin
          cnt_r[sensor_r]   <= '0;
          phase_r[sensor_r] <= PH_NOISE;
        end else begin
          cnt_r[sensor_r] <= cnt_inc;
        end
      end else if (cur_phase == PH_NOISE) begin
        if (done) begin
          cnt_r[sensor_r]   <= '0;
          phase_r[sensor_r] <= PH_RUN;
        end else begin
          cnt_r[sensor_r] <= cnt_inc;
        end
      end else begin
        phase_r[sensor_r] <= PH_RUN;
      end
    end
  end

  // Phase reported with the result: the state after this sample
  always_ff @(posedge clk) begin
    if (state_r == ST_FIN) begin
      priority if ((cur_phase == PH_AVG) && done) begin
        phase_res_r <= PH_NOISE;
      end else if ((cur_phase == PH_AVG) && !done) begin
        phase_res_r <= PH_AVG;
      end else if ((cur_phase == PH_NOISE) && !done) begin
        phase_res_r <= PH_NOISE;
      end else begin
        phase_res_r <= PH_RUN;
      end
    end
  end

  // Lane control
  assign ctrl.sensor = sensor_r;
  assign ctrl.phase  = cur_phase;
  assign ctrl.done   = done;
  assign ctrl.mul_en = (state_r == ST_MUL);
  assign ctrl.fin_en = (state_r == ST_FIN);
  assign ctrl.alpha  = alpha_eff;
  assign ctrl.n      = n_eff;

  // Axis lanes
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    imucal_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .sample (smp_r[g]),
      .stat   (stat[g])
    );
    assign q_valid_vec[g] = stat[g].q_valid;
  end

  // Merge lane results into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_WB) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_WB) && out_free) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        out_res_r[i]   <= stat[i].res;
        out_noise_r[i] <= stat[i].noise;
      end
      out_phase_r <= phase_res_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_x       = $signed(out_res_r[0]);
  assign out_y       = $signed(out_res_r[1]);
  assign out_z       = $signed(out_res_r[2]);
  assign out_noise_x = out_noise_r[0];
  assign out_noise_y = out_noise_r[1];
  assign out_noise_z = out_noise_r[2];
  assign out_phase   = out_phase_r;

`ifndef NO_ASSERTIONS
  // A running sensor never leaves the running phase
  a_accel_run_holds: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r[0] == PH_RUN |=> phase_r[0] == PH_RUN)
    else $error("accel left running phase");

  a_gyro_run_holds: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r[1] == PH_RUN |=> phase_r[1] == PH_RUN)
    else $error("gyro left running phase");

  // Counters rest at zero once a sensor runs
  a_run_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r[sensor_r] == PH_RUN) |-> (cnt_r[sensor_r] == '0))
    else $error("sample counter not cleared in running phase");

  // The divider only runs for a sensor that has just finished averaging
  a_div_after_avg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (phase_r[sensor_r] == PH_NOISE))
    else $error("offset division outside end of averaging");
`endif

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb - testbench of the IMU offset calibration and low-pass filter core
// Drives accelerometer and gyroscope samples with random bursts and output
// stalls. A scoreboard tracks the calibration phases, offsets, noise and the
// accelerometer filter, and checks every result field against its own forecast.
// ----------------------------------------------------------------------------
module tb;
  import imucal_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 40;
  localparam int MAX_REPORTS    = 40;
  localparam int RUN_PHASES     = 6;
  localparam int RUN_ITEMS      = 40;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] S_ALT_LO = 16'sh5555;
  localparam logic signed [SAMPLE_W-1:0] S_ALT_HI = 16'shaaaa;

  // One corrected sample as the core reports it
  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic [NOISE_OUT_W-1:0]  nx;
    logic [NOISE_OUT_W-1:0]  ny;
    logic [NOISE_OUT_W-1:0]  nz;
    logic [PHASE_W-1:0]      phase;
  } corrected_t;

  // --------------------------------------------------------------------------
  // Scoreboard: calibration state of both sensors and the pending results
  // --------------------------------------------------------------------------
  class imucal_scoreboard;
    longint           axis_sum[6];
    longint           axis_off[6];
    longint           axis_noise[6];
    longint           lp_state[3];
    int unsigned      phase_cnt[2];
    logic [PHASE_W-1:0] sns_phase[2];
    int unsigned      count_reg;
    int unsigned      alpha_reg;
    corrected_t       corrected_q[$];
    int               errors;
    int               reported;

    function new();
      count_reg = SAMPLE_COUNT_RST;
      alpha_reg = FILTER_ALPHA_RST;
      foreach (axis_sum[i]) begin
        axis_sum[i]   = 0;
        axis_off[i]   = 0;
        axis_noise[i] = 0;
      end
      foreach (lp_state[i]) lp_state[i] = 0;
      foreach (phase_cnt[i]) begin
        phase_cnt[i] = 0;
        sns_phase[i] = PH_AVG;
      end
      errors   = 0;
      reported = 0;
    endfunction

    function void write_reg(logic idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_SAMPLE_COUNT) begin
        count_reg = data;
      end else begin
        count_reg = count_reg;
        alpha_reg = data[ALPHA_W-1:0];
      end
    endfunction

    function int pending();
      return corrected_q.size();
    endfunction

    function logic [PHASE_W-1:0] phase_of(logic sensor);
      return sns_phase[(sensor == SNS_GYRO) ? 1 : 0];
    endfunction

    // Forecast the result of one accepted sample and advance the calibration
    function void take_sample(logic sensor, logic signed [SAMPLE_W-1:0] sx,
                              logic signed [SAMPLE_W-1:0] sy,
                              logic signed [SAMPLE_W-1:0] sz);
      longint     raw[3];
      longint     diff[3];
      longint     n;
      longint     a;
      longint     dev;
      int         s;
      int         base;
      int         i;
      corrected_t r;

      s    = (sensor == SNS_GYRO) ? 1 : 0;
      base = 3 * s;
      // Clamp the count and the weight to their working ranges
      n = count_reg;
      if (n < 1) n = 1;
      if (n > MAX_SAMPLES) n = MAX_SAMPLES;
      a = alpha_reg;
      if (a > ALPHA_ONE) a = ALPHA_ONE;

      raw[0] = sx;
      raw[1] = sy;
      raw[2] = sz;
      // Subtract the offset in force on arrival
      for (i = 0; i < 3; i++) diff[i] = raw[i] - axis_off[base + i];

      // Low-pass the accelerometer path in every phase
      if (sensor == SNS_ACCEL) begin
        for (i = 0; i < 3; i++) begin
          lp_state[i] = (a * diff[i] + (ALPHA_ONE - a) * lp_state[i]) / ALPHA_ONE;
          diff[i]     = lp_state[i];
        end
      end

      case (sns_phase[s])
        PH_AVG: begin
          for (i = 0; i < 3; i++) axis_sum[base + i] += raw[i];
          phase_cnt[s]++;
          if (phase_cnt[s] >= n) begin
            for (i = 0; i < 3; i++) axis_off[base + i] = axis_sum[base + i] / n;
            phase_cnt[s] = 0;
            sns_phase[s] = PH_NOISE;
          end
        end
        PH_NOISE: begin
          for (i = 0; i < 3; i++) begin
            dev = raw[i] - axis_off[base + i];
            if (dev < 0) dev = -dev;
            if (dev > axis_noise[base + i]) axis_noise[base + i] = dev;
          end
          phase_cnt[s]++;
          if (phase_cnt[s] >= n) begin
            phase_cnt[s] = 0;
            sns_phase[s] = PH_RUN;
          end
        end
        default: sns_phase[s] = PH_RUN;
      endcase

      r.x     = OUT_W'(diff[0]);
      r.y     = OUT_W'(diff[1]);
      r.z     = OUT_W'(diff[2]);
      r.nx    = NOISE_OUT_W'(axis_noise[base]);
      r.ny    = NOISE_OUT_W'(axis_noise[base + 1]);
      r.nz    = NOISE_OUT_W'(axis_noise[base + 2]);
      r.phase = sns_phase[s];
      corrected_q.push_back(r);
    endfunction

    function void flag_mismatch(string field, longint want, longint got);
      errors++;
      if (reported < MAX_REPORTS) begin
        reported++;
        $display("%0t  %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    // Compare one delivered result with the oldest forecast
    function void check_corrected(corrected_t got);
      corrected_t want;
      if (corrected_q.size() == 0) begin
        errors++;
        if (reported < MAX_REPORTS) begin
          reported++;
          $display("%0t  result with none outstanding: x=%0d y=%0d z=%0d phase=%0d",
                   $time, got.x, got.y, got.z, got.phase);
        end
        return;
      end
      want = corrected_q.pop_front();
      if (got.x !== want.x) flag_mismatch("out_x", want.x, got.x);
      if (got.y !== want.y) flag_mismatch("out_y", want.y, got.y);
      if (got.z !== want.z) flag_mismatch("out_z", want.z, got.z);
      if (got.nx !== want.nx) flag_mismatch("out_noise_x", want.nx, got.nx);
      if (got.ny !== want.ny) flag_mismatch("out_noise_y", want.ny, got.ny);
      if (got.nz !== want.nz) flag_mismatch("out_noise_z", want.nz, got.nz);
      if (got.phase !== want.phase) flag_mismatch("out_phase", want.phase, got.phase);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and the core
  // --------------------------------------------------------------------------
  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_opcode = SNS_ACCEL;
  logic signed [SAMPLE_W-1:0] in_sample_x = '0;
  logic signed [SAMPLE_W-1:0] in_sample_y = '0;
  logic signed [SAMPLE_W-1:0] in_sample_z = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [OUT_W-1:0]    out_x;
  logic signed [OUT_W-1:0]    out_y;
  logic signed [OUT_W-1:0]    out_z;
  logic [NOISE_OUT_W-1:0]     out_noise_x;
  logic [NOISE_OUT_W-1:0]     out_noise_y;
  logic [NOISE_OUT_W-1:0]     out_noise_z;
  logic [PHASE_W-1:0]         out_phase;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic                       cfg_index = CFG_SAMPLE_COUNT;
  logic [CFG_DATA_W-1:0]      cfg_wdata = '0;

  bit               hold_off_req = 1'b0;
  int               burst_left = 0;
  int               idle_cycles = 0;
  imucal_scoreboard sb = new();

  imu_offset_noise_calibrate_filter_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_sample_x (in_sample_x),
    .in_sample_y (in_sample_y),
    .in_sample_z (in_sample_z),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .out_noise_x (out_noise_x),
    .out_noise_y (out_noise_y),
    .out_noise_z (out_noise_z),
    .out_phase   (out_phase),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Monitor: note every accepted request and check every delivered result at the
  // rising edge, and watch for a stretch with no traffic at all
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    corrected_t got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_wdata);
      if (in_valid && in_ready) sb.take_sample(in_opcode, in_sample_x, in_sample_y, in_sample_z);
      if (out_valid && out_ready) begin
        got.x     = out_x;
        got.y     = out_y;
        got.z     = out_z;
        got.nx    = out_noise_x;
        got.ny    = out_noise_y;
        got.nz    = out_noise_z;
        got.phase = out_phase;
        sb.check_corrected(got);
      end
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall in segments of its own pattern; hold off on request
  // --------------------------------------------------------------------------
  initial begin
    int seg_left;
    int mode;
    seg_left = 0;
    mode     = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 2);
          seg_left = $urandom_range(8, 48);
        end
        seg_left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (seg_left % 5 == 0);
        endcase
        @(negedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------

  // Offer one sample request, at times idling between bursts, and hold it until taken
  task automatic push_sample(input logic sensor, input logic signed [SAMPLE_W-1:0] sx,
                             input logic signed [SAMPLE_W-1:0] sy,
                             input logic signed [SAMPLE_W-1:0] sz);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_opcode   <= sensor;
    in_sample_x <= sx;
    in_sample_y <= sy;
    in_sample_z <= sz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and wait until every forecast result has been delivered
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Write both registers with the core idle
  task automatic reconfigure(input logic [CFG_DATA_W-1:0] count,
                             input logic [CFG_DATA_W-1:0] alpha);
    settle();
    write_cfg(CFG_SAMPLE_COUNT, count);
    write_cfg(CFG_FILTER_ALPHA, alpha);
    cfg_valid <= 1'b0;
  endtask

  // Full-range reading, weighted towards the extremes
  function automatic logic signed [SAMPLE_W-1:0] wide_sample();
    case ($urandom_range(0, 7))
      0:       return S_MIN;
      1:       return S_MAX;
      2:       return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Reading close to rest whose spread grows with step, so the noise peak keeps moving
  function automatic logic signed [SAMPLE_W-1:0] quiet_sample(int step);
    int spread;
    spread = 4 + step / 2;
    if (step > 700 && $urandom_range(0, 15) == 0) return wide_sample();
    return SAMPLE_W'($urandom_range(0, 2 * spread) - spread);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int          step;
    int          run_idx;
    int          k;
    int unsigned alpha_pick;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: partial averaging on both sensors
    push_sample(SNS_ACCEL, S_MAX, S_MAX, S_MIN);
    push_sample(SNS_GYRO, 16'sd1, -16'sd1, 16'sd0);
    push_sample(SNS_ACCEL, S_MAX, S_MIN, S_MIN);

    // Count of zero acts as one and closes averaging early; offset overflows
    // the sample range; zero weight holds the filter
    reconfigure('0, '0);
    push_sample(SNS_ACCEL, S_MAX, S_MAX, S_MIN);
    push_sample(SNS_ACCEL, S_MIN, S_MIN, S_MAX);
    push_sample(SNS_ACCEL, '0, '0, '0);

    // Count above the maximum and weight above one; gyro averaging goes on
    reconfigure({CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}});
    push_sample(SNS_GYRO, S_MAX, S_MAX, S_MAX);
    push_sample(SNS_ACCEL, S_MAX, S_MAX, S_MAX);
    push_sample(SNS_GYRO, S_MIN, S_MIN, S_MIN);
    push_sample(SNS_GYRO, S_MAX, S_MIN, S_ALT_LO);
    push_sample(SNS_ACCEL, S_MIN, S_MIN, S_MIN);
    push_sample(SNS_GYRO, S_MIN, S_MAX, S_ALT_HI);

    // Count lowered below the gyro counter: next gyro sample closes averaging
    reconfigure(CFG_DATA_W'(3), CFG_DATA_W'(ALPHA_ONE));
    push_sample(SNS_GYRO, '0, '0, 16'sd1);
    push_sample(SNS_ACCEL, -16'sd1, 16'sd1, -16'sd1);

    // Gyro noise measurement over the full clamped count, mostly gyro traffic
    reconfigure({CFG_DATA_W{1'b1}}, CFG_DATA_W'(1));
    step = 0;
    while (sb.phase_of(SNS_GYRO) != PH_RUN) begin
      if (step == 150) hold_off_req = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        push_sample(SNS_ACCEL, wide_sample(), wide_sample(), wide_sample());
      end else begin
        push_sample(SNS_GYRO, quiet_sample(step), quiet_sample(step), quiet_sample(step));
      end
      step++;
    end

    // Both sensors running: sweep the filter weight
    for (run_idx = 0; run_idx < RUN_PHASES; run_idx++) begin
      case (run_idx)
        0:       alpha_pick = 0;
        1:       alpha_pick = ALPHA_ONE;
        2:       alpha_pick = ALPHA_ONE / 2;
        3:       alpha_pick = ALPHA_ONE + 1;
        default: alpha_pick = $urandom_range(0, 511);
      endcase
      reconfigure(CFG_DATA_W'($urandom_range(0, 2047)), CFG_DATA_W'(alpha_pick));
      for (k = 0; k < RUN_ITEMS; k++) begin
        push_sample(1'($urandom_range(0, 1)), wide_sample(), wide_sample(), wide_sample());
      end
    end

    // Drain and let any stray result show up
    settle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/imucal_pkg.sv
hw/rtl/imucal_div.sv
hw/rtl/imucal_lane.sv
hw/rtl/imu_offset_noise_calibrate_filter_core.sv
bench/tb.sv
